[rtl/core/lrn_pkg.sv]
// shared types, constants and table builders for the cross channel lrn unit
// no dependencies; used by lrn_ctrl, lrn_dp and cross_channel_lrn_unit
package lrn_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_RADIUS  = 7;
  localparam int SQ_W        = 32;
  localparam int SUM_W       = 36;
  localparam int ACC_W       = 60;
  localparam int DEN_W       = 64;
  localparam int FRAC_W      = 30;
  localparam int BACC_W      = 54;
  localparam int EXP_W       = 40;
  localparam int PROD_W      = 47;
  localparam int CNT_W       = 6;
  localparam int DIV_STEPS   = ACC_W;
  localparam int LOG_STEPS   = FRAC_W;
  localparam int FILL_MAX    = 15;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_ALPHA  = 2'd1,
    REG_BETA   = 2'd2,
    REG_BIAS   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_channel;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] norm_value;
    logic                          last_out;
  } out_t;

  typedef struct packed {
    logic             push;
    logic             push_zero;
    logic             clear;
    logic             sum_acc;
    logic [CNT_W-1:0] idx;
    logic             mul_lo;
    logic             mul_hi;
    logic             div_step;
    logic             den_load;
    logic             norm_step;
    logic             log_init;
    logic             log_step;
    logic             bmul_lo;
    logic             bmul_hi;
    logic             exp_init;
    logic             exp_step;
    logic             fin_mul;
    logic             out_load;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] radius;
    logic [3:0] fill;
    logic       special;
    logic       norm_done;
  } stat_t;

  typedef logic [FRAC_W:0] exp_coef_t;
  typedef exp_coef_t [LOG_STEPS-1:0] exp_table_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > x) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 64'd0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // factors 2^(2^-i) in q.30, i = 1..30
  function automatic exp_table_t build_exp_table();
    exp_table_t t;
    logic [63:0] c;
    c = 64'd1 << (FRAC_W + 1);
    for (int i = 0; i < LOG_STEPS; i++) begin
      c = isqrt64(c << FRAC_W);
      t[i] = c[FRAC_W:0];
    end
    return t;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

[rtl/core/lrn_ctrl.sv]
// controller state machine for the cross channel lrn unit
// depends on lrn_pkg; drives lrn_dp through cmd_t and reads stat_t
module lrn_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  logic          item_last,
  output logic          result_valid,
  input  logic          result_ready,
  input  lrn_pkg::stat_t stat,
  output lrn_pkg::cmd_t  cmd
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_SUM   = 17'h00002,
    S_MUL0  = 17'h00004,
    S_MUL1  = 17'h00008,
    S_DIV   = 17'h00010,
    S_DEN   = 17'h00020,
    S_CHK   = 17'h00040,
    S_NORM  = 17'h00080,
    S_LOG   = 17'h00100,
    S_BMUL0 = 17'h00200,
    S_BMUL1 = 17'h00400,
    S_EINIT = 17'h00800,
    S_EXP   = 17'h01000,
    S_FMUL  = 17'h02000,
    S_SHIFT = 17'h04000,
    S_OUT   = 17'h08000,
    S_NEXT  = 17'h10000
  } state_t;

  state_t state, state_next;
  logic [lrn_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [2:0] k, k_next;
  logic last_q, last_q_next;
  logic emit_last, emit_last_next;
  logic emit_now, emit_last_now;

  always_comb begin
    if (k != 3'd0) begin
      emit_now      = ({1'b0, stat.fill} + {2'b0, k}) > {2'b0, stat.radius};
      emit_last_now = (k == stat.radius);
    end else begin
      emit_now      = stat.fill > {1'b0, stat.radius};
      emit_last_now = last_q && (stat.radius == 3'd0);
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    k_next         = k;
    last_q_next    = last_q;
    emit_last_next = emit_last;
    cmd            = '0;
    cmd.idx        = cnt;
    cmd.out_last   = emit_last;
    item_ready     = 1'b0;
    result_valid   = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.push    = 1'b1;
          last_q_next = item_last;
          k_next      = 3'd0;
          cnt_next    = '0;
          state_next  = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_acc = 1'b1;
        cnt_next    = cnt + 1'b1;
        if (cnt[3:0] == {stat.radius, 1'b0}) begin
          emit_last_next = emit_last_now;
          state_next     = emit_now ? S_MUL0 : S_NEXT;
        end
      end
      S_MUL0: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == lrn_pkg::CNT_W'(lrn_pkg::DIV_STEPS - 1)) state_next = S_DEN;
      end
      S_DEN: begin
        cmd.den_load = 1'b1;
        state_next   = S_CHK;
      end
      S_CHK: begin
        state_next = stat.special ? S_SHIFT : S_NORM;
      end
      S_NORM: begin
        if (stat.norm_done) begin
          cmd.log_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_LOG;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_LOG: begin
        cmd.log_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == lrn_pkg::CNT_W'(lrn_pkg::LOG_STEPS - 1)) state_next = S_BMUL0;
      end
      S_BMUL0: begin
        cmd.bmul_lo = 1'b1;
        state_next  = S_BMUL1;
      end
      S_BMUL1: begin
        cmd.bmul_hi = 1'b1;
        state_next  = S_EINIT;
      end
      S_EINIT: begin
        cmd.exp_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_EXP;
      end
      S_EXP: begin
        cmd.exp_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == lrn_pkg::CNT_W'(lrn_pkg::LOG_STEPS - 1)) state_next = S_FMUL;
      end
      S_FMUL: begin
        cmd.fin_mul = 1'b1;
        state_next  = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.out_load = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        result_valid = 1'b1;
        if (result_ready) state_next = S_NEXT;
      end
      S_NEXT: begin
        cnt_next = '0;
        if (last_q && (k < stat.radius)) begin
          cmd.push_zero = 1'b1;
          k_next        = k + 3'd1;
          state_next    = S_SUM;
        end else begin
          if (last_q) cmd.clear = 1'b1;
          k_next     = 3'd0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      k         <= 3'd0;
      last_q    <= 1'b0;
      emit_last <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      k         <= k_next;
      last_q    <= last_q_next;
      emit_last <= emit_last_next;
    end
  end

endmodule

[rtl/core/lrn_dp.sv]
// datapath of the cross channel lrn unit: window, config registers, power unit
// depends on lrn_pkg; sequenced by lrn_ctrl through cmd_t
module lrn_dp #(
  parameter int MAX_RADIUS = lrn_pkg::MAX_RADIUS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lrn_pkg::in_t         item,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [23:0]          cfg_data,
  input  lrn_pkg::cmd_t        cmd,
  output lrn_pkg::stat_t       stat,
  output lrn_pkg::out_t        result
);

  localparam int WinDepth = 2 * MAX_RADIUS + 1;
  localparam int DlyDepth = MAX_RADIUS + 1;
  localparam int WinIw    = $clog2(WinDepth);
  localparam int DlyIw    = (DlyDepth > 1) ? $clog2(DlyDepth) : 1;
  localparam int SB       = lrn_pkg::SAMPLE_BITS;
  localparam int FW       = lrn_pkg::FRAC_W;

  logic [2:0]  radius;
  logic [23:0] alpha_scale;
  logic [17:0] beta_exp;
  logic [23:0] bias_term;

  logic [lrn_pkg::SQ_W-1:0]  square_window [WinDepth];
  logic [SB-1:0]             sample_delay  [DlyDepth];
  logic [lrn_pkg::SUM_W-1:0] window_sum;
  logic [3:0]                fill_count;

  logic [2:0]    eff_r;
  logic [SB-1:0] in_raw, in_mag;
  logic [lrn_pkg::SQ_W-1:0] in_sq;

  always_comb begin
    eff_r  = ({1'b0, radius} > 4'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius;
    in_raw = item.sample;
    in_mag = in_raw[SB-1] ? (SB'(0) - in_raw) : in_raw;
    in_sq  = lrn_pkg::SQ_W'(in_mag * in_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= 3'd2;
      alpha_scale <= 24'd1678;
      beta_exp    <= 18'd49152;
      bias_term   <= 24'd65536;
    end else if (cfg_valid) begin
      unique case (lrn_pkg::reg_index_t'(cfg_index))
        lrn_pkg::REG_RADIUS: radius      <= cfg_data[2:0];
        lrn_pkg::REG_ALPHA:  alpha_scale <= cfg_data;
        lrn_pkg::REG_BETA:   beta_exp    <= cfg_data[17:0];
        lrn_pkg::REG_BIAS:   bias_term   <= cfg_data;
        default: ;
      endcase
    end
  end

  // channel window
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < WinDepth; i++) square_window[i] <= '0;
      for (int i = 0; i < DlyDepth; i++) sample_delay[i] <= '0;
      window_sum <= '0;
      fill_count <= '0;
    end else if (cmd.push || cmd.push_zero) begin
      for (int i = 1; i < WinDepth; i++) square_window[i] <= square_window[i-1];
      for (int i = 1; i < DlyDepth; i++) sample_delay[i] <= sample_delay[i-1];
      square_window[0] <= cmd.push ? in_sq : '0;
      sample_delay[0]  <= cmd.push ? in_raw : '0;
      window_sum       <= '0;
      if (cmd.push && fill_count != 4'(lrn_pkg::FILL_MAX)) fill_count <= fill_count + 4'd1;
    end else if (cmd.sum_acc) begin
      window_sum <= window_sum
                  + lrn_pkg::SUM_W'(square_window[WinIw'(cmd.idx)]);
    end
  end

  // power unit registers
  logic [SB-1:0]                mag_q;
  logic                         neg_q;
  logic [lrn_pkg::ACC_W-1:0]    acc;
  logic [3:0]                   rem;
  logic [lrn_pkg::DEN_W-1:0]    den;
  logic [5:0]                   msb_pos;
  logic [FW:0]                  mant;
  logic [FW-1:0]                frac;
  logic [lrn_pkg::BACC_W-1:0]   bacc;
  logic [FW-1:0]                fbits;
  logic signed [9:0]            ipart;
  logic [FW:0]                  gain;
  logic [lrn_pkg::PROD_W-1:0]   prod;
  logic [SB-1:0]                res_value;
  logic                         res_last;

  logic [SB-1:0] dly_raw;
  logic [3:0]    divisor;
  logic [4:0]    div_t;
  logic          div_ge;
  logic [63:0]   sq_full;
  logic [31:0]   sq_t;
  logic [35:0]   lmag;
  logic          l_neg;
  logic [37:0]   qv;
  logic [lrn_pkg::EXP_W-1:0] ev;
  logic [63:0]   gprod;
  logic [63:0]   yv;
  logic [63:0]   lim;
  logic signed [10:0] sh_up, s_dn;
  logic [63:0]   prod64;
  logic [SB-1:0] y_sat;

  always_comb begin
    dly_raw = sample_delay[DlyIw'(eff_r)];
    divisor = {eff_r, 1'b1};
    div_t   = {rem, acc[lrn_pkg::ACC_W-1]};
    div_ge  = div_t >= {1'b0, divisor};
    sq_full = 64'(mant) * 64'(mant);
    sq_t    = sq_full[FW+31:FW];
    l_neg   = msb_pos < 6'd40;
    if (l_neg) lmag = {6'(6'd40 - msb_pos), 30'd0} - {6'd0, frac};
    else       lmag = {6'(msb_pos - 6'd40), frac};
    qv      = 38'((bacc + lrn_pkg::BACC_W'(1 << 15)) >> 16);
    ev      = l_neg ? {2'b0, qv} : (lrn_pkg::EXP_W'(0) - {2'b0, qv});
    gprod   = 64'(gain) * 64'(lrn_pkg::EXP_TABLE[cmd.idx[4:0]]);
  end

  always_comb begin
    prod64 = 64'(prod);
    sh_up  = {ipart[9], ipart} - 11'sd30;
    s_dn   = 11'sd30 - {ipart[9], ipart};
    if (mag_q == '0) begin
      yv = '0;
    end else if (beta_exp == '0) begin
      yv = 64'(mag_q);
    end else if (den == '0) begin
      yv = 64'd1 << 62;
    end else if (ipart >= 10'sd30) begin
      if (sh_up > 11'sd16) yv = 64'd1 << 62;
      else                 yv = prod64 << sh_up[4:0];
    end else begin
      if (s_dn > 11'sd50) yv = '0;
      else yv = (prod64 + (64'd1 << (s_dn[5:0] - 6'd1))) >> s_dn[5:0];
    end
    lim = neg_q ? (64'd1 << (SB - 1)) : ((64'd1 << (SB - 1)) - 64'd1);
    if (yv > lim) yv = lim;
    y_sat = neg_q ? (SB'(0) - yv[SB-1:0]) : yv[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      acc   <= lrn_pkg::ACC_W'(alpha_scale * window_sum[17:0]);
      rem   <= '0;
      mag_q <= dly_raw[SB-1] ? (SB'(0) - dly_raw) : dly_raw;
      neg_q <= dly_raw[SB-1];
    end
    if (cmd.mul_hi) begin
      acc <= acc + (lrn_pkg::ACC_W'(alpha_scale * window_sum[35:18]) << 18);
    end
    if (cmd.div_step) begin
      acc <= {acc[lrn_pkg::ACC_W-2:0], div_ge};
      rem <= div_ge ? 4'(div_t - {1'b0, divisor}) : div_t[3:0];
    end
    if (cmd.den_load) begin
      den     <= {16'd0, bias_term, 24'd0} + lrn_pkg::DEN_W'(acc);
      msb_pos <= 6'd63;
    end
    if (cmd.norm_step) begin
      den     <= den << 1;
      msb_pos <= msb_pos - 6'd1;
    end
    if (cmd.log_init) begin
      mant <= den[63:63-FW];
      frac <= '0;
    end
    if (cmd.log_step) begin
      mant <= sq_t[31] ? sq_t[31:1] : sq_t[FW:0];
      frac <= {frac[FW-2:0], sq_t[31]};
    end
    if (cmd.bmul_lo) bacc <= lrn_pkg::BACC_W'(beta_exp * lmag[17:0]);
    if (cmd.bmul_hi) bacc <= bacc + (lrn_pkg::BACC_W'(beta_exp * lmag[35:18]) << 18);
    if (cmd.exp_init) begin
      fbits <= ev[FW-1:0];
      ipart <= ev[lrn_pkg::EXP_W-1:FW];
      gain  <= (FW+1)'(1) << FW;
    end
    if (cmd.exp_step) begin
      fbits <= fbits << 1;
      if (fbits[FW-1]) gain <= gprod[2*FW:FW];
    end
    if (cmd.fin_mul) prod <= lrn_pkg::PROD_W'(mag_q * gain);
    if (cmd.out_load) begin
      res_value <= y_sat;
      res_last  <= cmd.out_last;
    end
  end

  always_comb begin
    stat.radius    = eff_r;
    stat.fill      = fill_count;
    stat.special   = (mag_q == '0) || (beta_exp == '0) || (den == '0);
    stat.norm_done = den[lrn_pkg::DEN_W-1];
    result.norm_value = res_value;
    result.last_out   = res_last;
  end

endmodule

[rtl/core/cross_channel_lrn_unit.sv]
// top level of the cross channel local response normalization unit
// depends on lrn_pkg, lrn_ctrl and lrn_dp
//
// usage: the channel samples of one pixel enter on the item channel in channel
// order, last_channel set on the final one. results leave on the result channel,
// lagging by radius channels; the last channel flushes the remaining ones, the
// final one with last_out set. both channels use valid/ready transactions.
// configuration: cfg_index selects radius, alpha_scale, beta_exp, bias_term in
// that order; cfg_ready is always high; write only while the unit is idle.
// sequencing: one item is taken at a time. a step that gives no result runs
// the window sum, one entry per cycle. a result adds a bit serial divide by
// 2r+1, a normalizing shift, the log squaring loop and the exponent product
// loop. a zero sample, zero beta or zero denominator skips the normalizing
// shift and the log and exponent loops.
// reset: the config and control registers return to their reset values and
// the window is cleared.
// a stalled result channel holds the result register and the unit waits.
module cross_channel_lrn_unit #(
  parameter int MAX_RADIUS = lrn_pkg::MAX_RADIUS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  lrn_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_ready,
  output lrn_pkg::out_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [23:0]   cfg_data
);

  lrn_pkg::cmd_t  cmd;
  lrn_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  lrn_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_last    (item.last_channel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  lrn_dp #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

[tb/tb_cross_channel_lrn_unit.sv]
// self-checking testbench for cross_channel_lrn_unit: pixels of channel samples
// against a bit-exact normalization predictor in a small scoreboard class
// depends on lrn_pkg and the cross_channel_lrn_unit rtl
`timescale 1ns / 1ps

module tb_cross_channel_lrn_unit;

  class lrn_scoreboard;
    bit [2:0]  radius;
    bit [23:0] alpha;
    bit [17:0] beta;
    bit [23:0] bias;
    bit [63:0] sq_win[15];
    bit [15:0] raw_dly[8];
    bit [63:0] win_sum;
    int        fill;
    lrn_pkg::out_t norm_q[$];
    int        errors;

    function new();
      radius = 3'd2;
      alpha  = 24'd1678;
      beta   = 18'd49152;
      bias   = 24'd65536;
      errors = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (sq_win[i]) sq_win[i] = '0;
      foreach (raw_dly[i]) raw_dly[i] = '0;
      win_sum = '0;
      fill = 0;
    endfunction

    function void write_reg(lrn_pkg::reg_index_t idx, bit [23:0] data);
      case (idx)
        lrn_pkg::REG_RADIUS: radius = data[2:0];
        lrn_pkg::REG_ALPHA:  alpha  = data;
        lrn_pkg::REG_BETA:   beta   = data[17:0];
        lrn_pkg::REG_BIAS:   bias   = data;
        default: ;
      endcase
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] root;
      bit [63:0] b;
      root = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= root + b) begin
          v = v - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    // |x| * den^-beta in q8.8 lsbs, before saturation
    function bit [63:0] scaled_mag(bit [63:0] mag, bit [63:0] den);
      bit [63:0] huge;
      bit [63:0] m;
      bit [63:0] frac;
      bit [63:0] lmag;
      bit [63:0] q;
      bit [63:0] f;
      bit [63:0] g;
      bit [63:0] c;
      bit [63:0] prod;
      longint    l;
      longint    e;
      longint    ip;
      int        p;
      huge = 64'd1 << 62;
      frac = '0;
      p = 0;
      if (mag == 0) return 0;
      if (beta == 0) return mag;
      if (den == 0) return huge;
      for (int i = 0; i < 64; i++) if (den[i]) p = i;
      m = (p >= 30) ? (den >> (p - 30)) : (den << (30 - p));
      for (int i = 1; i <= 30; i++) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          frac = frac | (64'd1 << (30 - i));
        end
      end
      l = (longint'(p) - 40) * (longint'(1) << 30) + longint'(frac);
      lmag = (l < 0) ? 64'(-l) : 64'(l);
      q = (64'(beta) * lmag + (64'd1 << 15)) >> 16;
      e = (l < 0) ? longint'(q) : -longint'(q);
      f = 64'(e) & ((64'd1 << 30) - 1);
      ip = (e - longint'(f)) / (longint'(1) << 30);
      g = 64'd1 << 30;
      c = 64'd2 << 30;
      for (int i = 1; i <= 30; i++) begin
        c = int_sqrt(c << 30);
        if (f[30 - i]) g = (g * c) >> 30;
      end
      prod = mag * g;
      if (ip >= 30) begin
        if (ip - 30 > 16) return huge;
        return prod << (ip - 30);
      end
      if (30 - ip > 50) return 0;
      return (prod + (64'd1 << (30 - ip - 1))) >> (30 - ip);
    endfunction

    function void shift_in(bit [63:0] sq, bit [15:0] raw);
      bit [63:0] s;
      s = '0;
      for (int i = 14; i > 0; i--) sq_win[i] = sq_win[i-1];
      sq_win[0] = sq;
      for (int i = 7; i > 0; i--) raw_dly[i] = raw_dly[i-1];
      raw_dly[0] = raw;
      for (int i = 0; i < 2 * radius + 1; i++) s = s + sq_win[i];
      win_sum = s & ((64'd1 << 36) - 1);
    endfunction

    function void predict_norm(bit last);
      bit [15:0] raw;
      bit        neg;
      bit [63:0] mag;
      bit [63:0] den;
      bit [63:0] y;
      bit [63:0] lim;
      lrn_pkg::out_t o;
      raw = raw_dly[radius];
      neg = raw[15];
      mag = neg ? (64'd65536 - raw) : 64'(raw);
      den = (64'(bias) << 24) + (64'(alpha) * win_sum) / (2 * radius + 1);
      y = scaled_mag(mag, den);
      lim = neg ? 64'd32768 : 64'd32767;
      if (y > lim) y = lim;
      o.norm_value = neg ? 16'(-y) : 16'(y);
      o.last_out = last;
      norm_q.push_back(o);
    endfunction

    function void note_item(lrn_pkg::in_t it);
      bit [15:0] raw;
      bit [63:0] mag;
      raw = it.sample;
      mag = raw[15] ? (64'd65536 - raw) : 64'(raw);
      shift_in(mag * mag, raw);
      if (fill < 15) fill++;
      if (fill > radius) predict_norm(it.last_channel && radius == 0);
      if (it.last_channel) begin
        for (int k = 1; k <= radius; k++) begin
          shift_in(0, 0);
          if (fill + k > radius) predict_norm(k == radius);
        end
        clear_window();
      end
    endfunction

    function void check_result(lrn_pkg::out_t got);
      lrn_pkg::out_t want;
      if (norm_q.size() == 0) begin
        $display("%0t: unexpected result norm_value %0d last_out %0b",
                 $time, got.norm_value, got.last_out);
        errors++;
        return;
      end
      want = norm_q.pop_front();
      if (got.norm_value !== want.norm_value) begin
        $display("%0t: norm_value mismatch: expected %0d actual %0d",
                 $time, want.norm_value, got.norm_value);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $display("%0t: last_out mismatch: expected %0b actual %0b",
                 $time, want.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_ready;
  lrn_pkg::in_t  item;
  logic       result_valid;
  logic       result_ready;
  lrn_pkg::out_t result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [23:0] cfg_data;

  lrn_scoreboard sb;
  int sender_idle_pct;
  int stall_pct;
  int hold_request;
  int hold_left;
  int items_sent;

  cross_channel_lrn_unit uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver side, with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (result_valid && result_ready) sb.check_result(result);
      if (hold_request > 0) begin
        hold_left <= hold_request;
        hold_request = 0;
        result_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(logic signed [15:0] s, logic last);
    lrn_pkg::in_t it;
    it.sample = s;
    it.last_channel = last;
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.norm_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(lrn_pkg::reg_index_t idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_cfg(logic [2:0] r, logic [23:0] a, logic [17:0] b, logic [23:0] k);
    write_cfg(lrn_pkg::REG_RADIUS, 24'(r));
    write_cfg(lrn_pkg::REG_ALPHA, a);
    write_cfg(lrn_pkg::REG_BETA, 24'(b));
    write_cfg(lrn_pkg::REG_BIAS, k);
  endtask

  function automatic logic signed [15:0] rand_sample();
    logic [15:0] v;
    case ($urandom_range(5))
      0: v = 16'($urandom_range(0, 511));
      1: v = -16'($urandom_range(0, 511));
      2: v = 16'($urandom_range(0, 3));
      3: v = $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_pixel(int n);
    for (int i = 0; i < n; i++) send_item(rand_sample(), i == n - 1);
  endtask

  task automatic random_phase(int count, int max_len);
    int n;
    while (count > 0) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(16, 20) : $urandom_range(1, max_len);
      send_pixel(n);
      count -= n;
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = lrn_pkg::REG_RADIUS;
    cfg_data = '0;
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_request = 0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pixels with reset settings
    send_item(16'sh7fff, 1'b0);
    send_item(-16'sh8000, 1'b0);
    send_item(16'sh0000, 1'b0);
    send_item(16'sh0001, 1'b0);
    send_item(-16'sh0001, 1'b1);
    send_item(16'sh0100, 1'b1);
    send_item(-16'sh0200, 1'b0);
    send_item(16'sh0300, 1'b1);
    drain();
    // radius change in the middle of a pixel
    send_item(16'sh0400, 1'b0);
    send_item(16'sh0500, 1'b0);
    send_item(-16'sh0600, 1'b0);
    drain();
    write_cfg(lrn_pkg::REG_RADIUS, 24'd0);
    send_item(16'sh0700, 1'b0);
    send_item(16'sh7fff, 1'b1);
    drain();
    // zero beta, then zero denominator
    set_cfg(3'd1, 24'd1678, 18'd0, 24'd65536);
    send_item(-16'sh1234, 1'b0);
    send_item(16'sh4321, 1'b1);
    drain();
    set_cfg(3'd1, 24'd0, 18'd49152, 24'd0);
    send_item(-16'sh0123, 1'b0);
    send_item(16'sh0000, 1'b0);
    send_item(16'sh0456, 1'b1);
    drain();
    // long pixel at maximum radius
    set_cfg(3'd7, 24'hffffff, 18'h3ffff, 24'hffffff);
    send_pixel(18);
    drain();

    set_cfg(3'd2, 24'd1678, 18'd49152, 24'd65536);
    random_phase(70, 8);
    drain();
    set_cfg(3'd7, 24'($urandom), 18'($urandom), 24'($urandom));
    sender_idle_pct = 54;
    random_phase(60, 17);
    drain();
    set_cfg(3'd0, 24'hffffff, 18'h3ffff, 24'd0);
    sender_idle_pct = 0;
    stall_pct = 54;
    random_phase(60, 6);
    drain();
    set_cfg(3'd4, 24'($urandom), 18'($urandom_range(0, 131071)), 24'($urandom));
    sender_idle_pct = 28;
    stall_pct = 28;
    random_phase(60, 12);
    drain();
    set_cfg(3'd3, 24'd0, 18'd0, 24'd0);
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_request = 3000;
    random_phase(60, 10);
    drain();
    set_cfg(3'($urandom), 24'($urandom), 18'($urandom), 24'($urandom));
    stall_pct = 54;
    random_phase(60, 10);

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.norm_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
